// File: rtl/hbc_pkg.sv
package hbc_pkg;

    // Field widths fixed by the channel formats
    localparam int SLOT_W   = 9;
    localparam int DEV_W    = 16;
    localparam int BLK_W    = 32;
    localparam int CNT_W    = 8;
    localparam int TIME_W   = 32;

    // Hash multiplier and the largest reference count
    localparam logic [31:0]      HASH_MUL = 32'd263;
    localparam logic [CNT_W-1:0] CNT_MAX  = 8'd255;

    // Command codes
    typedef enum logic [1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } t_cmd;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_BUF = 2'd1,
        ST_COUNT  = 2'd2
    } t_status;

    // Request payload
    typedef struct packed {
        logic [1:0]        cmd;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block_number;
        logic [SLOT_W-1:0] slot_in;
        logic [TIME_W-1:0] now;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              needs_read;
        logic              hit;
        logic [1:0]        status;
    } t_rsp;

    // One cache entry as held in the memory
    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic              valid;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] rtime;
    } t_entry;

endpackage

// File: rtl/hbc_ifs.sv
// Request channel: valid/ready handshake with the request payload.
interface hbc_req_if
    import hbc_pkg::*;
;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel: valid/ready handshake with the response payload.
interface hbc_rsp_if
    import hbc_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/hashed_buffer_cache_lru.sv
// Set-associative buffer cache with least-recently-released replacement.
// Requests arrive on i_req (acquire, release, pin, unpin) and each one
// produces exactly one response on o_rsp; a transaction completes when
// valid and ready are both high at a rising edge of i_clk.
// All entries live in one synchronous memory with a registered read port.
// An acquire hashes device and block, reduces the hash to a set four bits
// per cycle, then reads the WAYS entries of that set one per cycle, looking
// for a tag match and the oldest unreferenced way at once.
// Release, pin and unpin go through one read, one check and one write-back;
// a slot out of range is answered without reading the memory.
// One request is in progress at a time; i_req.ready is high while idle.
// After reset the block clears all SETS*WAYS entries of the memory, one per
// cycle, before it takes its first request.
// The response sits in an output register; a request may be accepted
// while it waits, but the next response and its memory write-back are
// held until the receiver has taken the previous one.
module hashed_buffer_cache_lru
    import hbc_pkg::*;
#(
    parameter int WAYS = 32,
    parameter int SETS = 13
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hbc_req_if.sink   i_req,
    hbc_rsp_if.source o_rsp
);

    localparam int ENTRIES = SETS * WAYS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int MOD_STEPS = 8;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_BASE,
        S_SCAN,
        S_DECIDE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Request held for the duration of one transaction
    logic [1:0]         r_cmd;
    logic [DEV_W-1:0]   r_dev;
    logic [BLK_W-1:0]   r_blk;
    logic [SLOT_W-1:0]  r_slot_in;
    logic [TIME_W-1:0]  r_now;

    // Hash and set reduction
    logic [31:0]        r_hash;
    logic [SET_W-1:0]   r_rem;
    logic [2:0]         r_mcnt;
    logic [ADDR_W-1:0]  r_base;

    // Set scan
    logic [WAY_W-1:0]   r_way;
    logic               r_issue;
    logic               r_chk;
    logic [WAY_W-1:0]   r_chk_way;
    logic               r_hit;
    logic [WAY_W-1:0]   r_hit_way;
    t_entry             r_hit_ent;
    logic               r_found;
    logic [WAY_W-1:0]   r_best_way;
    logic [TIME_W-1:0]  r_best_time;

    // Pending write-back and response
    logic               r_wr_en;
    logic [ADDR_W-1:0]  r_wr_addr;
    t_entry             r_wr_data;
    t_rsp               r_res;
    t_rsp               r_out;
    logic               r_out_vld;

    // Entry memory
    t_entry             r_mem [ENTRIES];
    t_entry             r_rd_data;

    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_entry             mem_wdata;
    logic               out_free;
    logic [SET_W-1:0]   n_rem;
    logic               chk_hit;
    logic               chk_free;
    logic [ADDR_W-1:0]  hit_addr;
    logic [ADDR_W-1:0]  best_addr;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;
    assign out_free    = !r_out_vld || o_rsp.ready;

    assign hit_addr  = r_base + ADDR_W'(r_hit_way);
    assign best_addr = r_base + ADDR_W'(r_best_way);

    // Read address: the slot for single-entry commands, else the scan way
    always_comb begin
        if (r_state == S_SLOT_RD) begin
            rd_addr = ADDR_W'(r_slot_in);
        end else begin
            rd_addr = r_base + ADDR_W'(r_way);
        end
    end

    // Write port: zeroes during the clearing pass, else the write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = (r_state == S_DONE) && r_wr_en && out_free;
            mem_waddr = r_wr_addr;
            mem_wdata = r_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Four restoring steps of the remainder by SETS per cycle
    always_comb begin
        logic [SET_W:0] t;
        n_rem = r_rem;
        for (int i = 0; i < 4; i++) begin
            t = {n_rem, r_hash[31-i]};
            if (t >= (SET_W+1)'(SETS)) begin
                t = t - (SET_W+1)'(SETS);
            end
            n_rem = t[SET_W-1:0];
        end
    end

    // Tag match and free-way test on the entry read back during the scan
    assign chk_hit  = (r_rd_data.dev == r_dev) && (r_rd_data.blk == r_blk);
    assign chk_free = (r_rd_data.cnt == '0);

    // Sequencer, scan bookkeeping and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
            r_issue    <= 1'b0;
            r_chk      <= 1'b0;
            r_hit      <= 1'b0;
            r_found    <= 1'b0;
            r_wr_en    <= 1'b0;
        end else begin
            // The output register empties when taken, unless it is refilled now
            if (r_out_vld && o_rsp.ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end

                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd     <= i_req.data.cmd;
                        r_dev     <= i_req.data.device;
                        r_blk     <= i_req.data.block_number;
                        r_slot_in <= i_req.data.slot_in;
                        r_now     <= i_req.data.now;
                        r_wr_en   <= 1'b0;
                        if (i_req.data.cmd == CMD_ACQUIRE) begin
                            r_state <= S_HASH;
                        end else if (32'(i_req.data.slot_in) >= 32'(ENTRIES)) begin
                            // Slot outside the cache: answer at once
                            r_res.slot_out   <= i_req.data.slot_in;
                            r_res.needs_read <= 1'b0;
                            r_res.hit        <= 1'b0;
                            r_res.status     <= ST_COUNT;
                            r_state          <= S_DONE;
                        end else begin
                            r_state <= S_SLOT_RD;
                        end
                    end
                end

                S_HASH: begin
                    r_hash  <= 32'(r_dev) * HASH_MUL + r_blk;
                    r_rem   <= '0;
                    r_mcnt  <= '0;
                    r_state <= S_MOD;
                end

                S_MOD: begin
                    r_rem  <= n_rem;
                    r_hash <= {r_hash[27:0], 4'b0000};
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 3'(MOD_STEPS - 1)) begin
                        r_state <= S_BASE;
                    end
                end

                S_BASE: begin
                    r_base  <= ADDR_W'(r_rem) * ADDR_W'(WAYS);
                    r_way   <= '0;
                    r_issue <= 1'b1;
                    r_chk   <= 1'b0;
                    r_hit   <= 1'b0;
                    r_found <= 1'b0;
                    r_state <= S_SCAN;
                end

                S_SCAN: begin
                    // Issue one read per cycle until the last way
                    if (r_issue) begin
                        if (r_way == WAY_W'(WAYS - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_way <= r_way + 1'b1;
                        end
                    end
                    r_chk     <= r_issue;
                    r_chk_way <= r_way;

                    // Check the entry read in the previous cycle
                    if (r_chk) begin
                        if (!r_hit && chk_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_way <= r_chk_way;
                            r_hit_ent <= r_rd_data;
                        end
                        if (chk_free && (!r_found || r_best_time > r_rd_data.rtime)) begin
                            r_found     <= 1'b1;
                            r_best_way  <= r_chk_way;
                            r_best_time <= r_rd_data.rtime;
                        end
                        if (r_chk_way == WAY_W'(WAYS - 1)) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end

                S_DECIDE: begin
                    if (r_hit) begin
                        r_res.slot_out <= SLOT_W'(hit_addr);
                        r_res.hit      <= 1'b1;
                        r_wr_addr      <= hit_addr;
                        if (r_hit_ent.cnt == CNT_MAX) begin
                            r_res.needs_read <= 1'b0;
                            r_res.status     <= ST_COUNT;
                        end else begin
                            r_res.needs_read <= !r_hit_ent.valid;
                            r_res.status     <= ST_OK;
                            r_wr_en          <= 1'b1;
                            r_wr_data        <= '{dev: r_hit_ent.dev, blk: r_hit_ent.blk,
                                                  valid: 1'b1, cnt: r_hit_ent.cnt + 1'b1,
                                                  rtime: r_hit_ent.rtime};
                        end
                    end else if (r_found) begin
                        // Take over the oldest unreferenced way
                        r_res.slot_out   <= SLOT_W'(best_addr);
                        r_res.needs_read <= 1'b1;
                        r_res.hit        <= 1'b0;
                        r_res.status     <= ST_OK;
                        r_wr_en          <= 1'b1;
                        r_wr_addr        <= best_addr;
                        r_wr_data        <= '{dev: r_dev, blk: r_blk, valid: 1'b1,
                                              cnt: CNT_W'(1), rtime: r_best_time};
                    end else begin
                        r_res.slot_out   <= '0;
                        r_res.needs_read <= 1'b0;
                        r_res.hit        <= 1'b0;
                        r_res.status     <= ST_NO_BUF;
                    end
                    r_state <= S_DONE;
                end

                S_SLOT_RD: begin
                    r_state <= S_SLOT_CHK;
                end

                S_SLOT_CHK: begin
                    r_res.slot_out   <= r_slot_in;
                    r_res.needs_read <= 1'b0;
                    r_res.hit        <= 1'b0;
                    r_wr_addr        <= ADDR_W'(r_slot_in);
                    r_wr_data.dev    <= r_rd_data.dev;
                    r_wr_data.blk    <= r_rd_data.blk;
                    r_wr_data.valid  <= r_rd_data.valid;
                    // Pin counts up; release and unpin count down
                    if (r_cmd == CMD_PIN) begin
                        r_wr_data.cnt <= r_rd_data.cnt + 1'b1;
                    end else begin
                        r_wr_data.cnt <= r_rd_data.cnt - 1'b1;
                    end
                    // A release that drops the last reference stamps the time
                    if (r_cmd == CMD_RELEASE && r_rd_data.cnt == CNT_W'(1)) begin
                        r_wr_data.rtime <= r_now;
                    end else begin
                        r_wr_data.rtime <= r_rd_data.rtime;
                    end
                    if (r_cmd == CMD_PIN) begin
                        if (r_rd_data.cnt == CNT_MAX) begin
                            r_res.status <= ST_COUNT;
                        end else begin
                            r_res.status <= ST_OK;
                            r_wr_en      <= 1'b1;
                        end
                    end else begin
                        if (r_rd_data.cnt == '0) begin
                            r_res.status <= ST_COUNT;
                        end else begin
                            r_res.status <= ST_OK;
                            r_wr_en      <= 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_wr_en   <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/hbc_chk.sv
// Port-level checks on the cache's request and response channels.
module hbc_chk
    import hbc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    // A stalled response stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response dropped or changed while stalled");

    // A request accepted while idle is answered only through the response register,
    // never in the cycle it is accepted; the block takes no request in the cycle
    // after one was accepted.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while one is in progress");

    // The no-buffer status carries no slot, no read and no hit.
    a_no_buf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.status == ST_NO_BUF |->
            i_rsp_data.slot_out == '0 && !i_rsp_data.needs_read && !i_rsp_data.hit)
        else $error("no-buffer response with payload set");

    // A disk read is only requested by a successful acquire.
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.needs_read |-> i_rsp_data.status == ST_OK)
        else $error("disk read requested on a failed transaction");

    // Status code three is never produced.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_data.status == ST_OK || i_rsp_data.status == ST_NO_BUF
            || i_rsp_data.status == ST_COUNT)
        else $error("response status out of range");

endmodule

bind hashed_buffer_cache_lru hbc_chk u_hbc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// File: tb/hashed_buffer_cache_lru_tb.sv
`timescale 1ns / 100ps

module hashed_buffer_cache_lru_tb
    import hbc_pkg::*;
;

    localparam int WAYS           = 32;
    localparam int SETS           = 13;
    localparam int NUM_SLOTS      = SETS * WAYS;
    localparam int RAND_ITEMS     = 800;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        bit [DEV_W-1:0] dev;
        bit [BLK_W-1:0] blk;
    } t_key;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hbc_req_if req_if ();
    hbc_rsp_if rsp_if ();

    hashed_buffer_cache_lru #(
        .WAYS(WAYS),
        .SETS(SETS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the cache contents, updated as each request is accepted.
    bit [DEV_W-1:0]  c_dev   [NUM_SLOTS];
    bit [BLK_W-1:0]  c_blk   [NUM_SLOTS];
    bit              c_valid [NUM_SLOTS];
    bit [CNT_W-1:0]  c_cnt   [NUM_SLOTS];
    bit [TIME_W-1:0] c_time  [NUM_SLOTS];

    t_req pending_reqs [$];
    t_rsp want_rsps [$];
    t_key key_pool [$];

    int issued_cnt   = 0;
    int answered_cnt = 0;
    int mismatches   = 0;
    int cycles       = 0;
    int idle_cycles  = 0;
    int n_hit        = 0;
    int n_miss       = 0;
    int n_full       = 0;
    int n_cnt_err    = 0;
    bit [31:0] now_tick = 0;

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the response to one request and applies it to the shadow cache.
    function automatic t_rsp cache_apply(t_req r);
        t_rsp       rsp;
        bit [31:0]  hash;
        int         base;
        int         e;
        int         pick;
        bit         found;

        rsp = '0;
        if (t_cmd'(r.cmd) == CMD_ACQUIRE) begin
            hash = r.device * HASH_MUL + r.block_number;
            base = int'(hash % SETS) * WAYS;
            // A matching tag wins regardless of the valid mark.
            for (int w = 0; w < WAYS; w++) begin
                e = base + w;
                if (c_dev[e] == r.device && c_blk[e] == r.block_number) begin
                    rsp.slot_out = SLOT_W'(e);
                    rsp.hit      = 1'b1;
                    if (c_cnt[e] == CNT_MAX) begin
                        rsp.status = ST_COUNT;
                    end else begin
                        c_cnt[e]       = c_cnt[e] + 1'b1;
                        rsp.needs_read = !c_valid[e];
                        c_valid[e]     = 1'b1;
                    end
                    return rsp;
                end
            end
            // Miss: the unreferenced way released longest ago, first one on a tie.
            found = 1'b0;
            pick  = 0;
            for (int w = 0; w < WAYS; w++) begin
                e = base + w;
                if (c_cnt[e] == 0 && (!found || c_time[e] < c_time[pick])) begin
                    pick  = e;
                    found = 1'b1;
                end
            end
            if (!found) begin
                rsp.status = ST_NO_BUF;
                return rsp;
            end
            c_dev[pick]    = r.device;
            c_blk[pick]    = r.block_number;
            c_cnt[pick]    = CNT_W'(1);
            c_valid[pick]  = 1'b1;
            rsp.slot_out   = SLOT_W'(pick);
            rsp.needs_read = 1'b1;
            return rsp;
        end

        rsp.slot_out = r.slot_in;
        if (r.slot_in >= NUM_SLOTS) begin
            rsp.status = ST_COUNT;
        end else if (t_cmd'(r.cmd) == CMD_PIN) begin
            if (c_cnt[r.slot_in] == CNT_MAX) begin
                rsp.status = ST_COUNT;
            end else begin
                c_cnt[r.slot_in] = c_cnt[r.slot_in] + 1'b1;
            end
        end else if (c_cnt[r.slot_in] == 0) begin
            rsp.status = ST_COUNT;
        end else begin
            c_cnt[r.slot_in] = c_cnt[r.slot_in] - 1'b1;
            // Only a release that frees the entry stamps the time.
            if (t_cmd'(r.cmd) == CMD_RELEASE && c_cnt[r.slot_in] == 0) begin
                c_time[r.slot_in] = r.now;
            end
        end
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Stimulus helpers.
    function automatic void send(t_cmd cmd, bit [DEV_W-1:0] dev, bit [BLK_W-1:0] blk,
                                 bit [SLOT_W-1:0] slot, bit [TIME_W-1:0] now);
        t_req r;

        r.cmd          = cmd;
        r.device       = dev;
        r.block_number = blk;
        r.slot_in      = slot;
        r.now          = now;
        pending_reqs.push_back(r);
        issued_cnt++;
    endfunction

    // Release times: fully random, small values that tie, extremes, or a rising tick.
    function automatic bit [TIME_W-1:0] pick_now();
        now_tick += $urandom_range(1, 1000);
        case ($urandom_range(0, 3))
            0: begin
                return $urandom;
            end
            1: begin
                return $urandom_range(0, 3);
            end
            2: begin
                return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            end
            default: begin
                return now_tick;
            end
        endcase
    endfunction

    function automatic void send_acquire(t_key k);
        send(CMD_ACQUIRE, k.dev, k.blk, SLOT_W'($urandom_range(0, 511)), $urandom);
    endfunction

    function automatic void send_slot(t_cmd cmd, int slot);
        send(cmd, DEV_W'($urandom), $urandom, SLOT_W'(slot), pick_now());
    endfunction

    // A random device/block pair whose hash lands in the given set.
    function automatic t_key key_in_set(int s);
        t_key            k;
        longint unsigned h;

        k.dev = DEV_W'($urandom);
        h     = 64'($urandom);
        h     = h - (h % SETS) + s;
        if (h > 64'hFFFF_FFFF) begin
            h = h - SETS;
        end
        k.blk = h[31:0] - k.dev * HASH_MUL;
        return k;
    endfunction

    function automatic t_key fresh_key(int s);
        t_key k;

        k = key_in_set(s);
        key_pool.push_back(k);
        if (key_pool.size() > 48) begin
            void'(key_pool.pop_front());
        end
        return k;
    endfunction

    // Holds the sender back until every response so far has been checked.
    task automatic wait_idle();
        while (answered_cnt != issued_cnt) begin
            @(negedge i_clk);
        end
    endtask

    // Mixed traffic on a few busy sets, working on entries that are held.
    task automatic mix_batch();
        int   hot [3];
        int   held [$];
        int   roll;
        int   slot;
        t_key k;
        t_cmd op;

        for (int i = 0; i < 3; i++) begin
            hot[i] = $urandom_range(0, SETS - 1);
        end
        for (int e = 0; e < NUM_SLOTS; e++) begin
            if (c_cnt[e] != 0) begin
                held.push_back(e);
            end
        end
        repeat (16) begin
            roll = $urandom_range(0, 99);
            if (roll < 42) begin
                if (key_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end else begin
                    k = fresh_key(hot[$urandom_range(0, 2)]);
                end
                send_acquire(k);
            end else if (roll < 95) begin
                op = (roll < 77) ? CMD_RELEASE : (roll < 85) ? CMD_PIN : CMD_UNPIN;
                if (held.size() != 0 && $urandom_range(0, 4) != 0) begin
                    slot = held[$urandom_range(0, held.size() - 1)];
                end else begin
                    slot = $urandom_range(0, NUM_SLOTS - 1);
                end
                send_slot(op, slot);
            end else begin
                // Noise, including slots beyond the end of the cache.
                send_slot(t_cmd'($urandom_range(1, 3)), $urandom_range(0, 511));
            end
        end
    endtask

    // Overfill one set, free most of it with assorted times, then refill.
    task automatic fill_set();
        int   s;
        t_key k;

        s = $urandom_range(0, SETS - 1);
        repeat (WAYS + 2) begin
            k = fresh_key(s);
            send_acquire(k);
        end
        wait_idle();
        for (int w = 0; w < WAYS; w++) begin
            if (c_cnt[s * WAYS + w] != 0 && $urandom_range(0, 7) != 0) begin
                send_slot(CMD_RELEASE, s * WAYS + w);
            end
        end
        repeat (4) begin
            k = fresh_key(s);
            send_acquire(k);
        end
    endtask

    // Drive one entry's count to its ceiling, then push past it by pin and by acquire.
    task automatic saturate_slot();
        int   s;
        int   e;
        int   n;
        t_key k;

        s = $urandom_range(0, SETS - 1);
        k = fresh_key(s);
        send_acquire(k);
        wait_idle();
        e = -1;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (c_dev[s * WAYS + w] == k.dev && c_blk[s * WAYS + w] == k.blk) begin
                e = s * WAYS + w;
            end
        end
        if (e >= 0) begin
            n = int'(CNT_MAX) - int'(c_cnt[e]);
            repeat (n) begin
                send_slot(CMD_PIN, e);
            end
            send_slot(CMD_PIN, e);
            send_acquire(k);
            send_slot(CMD_RELEASE, e);
            send_slot(CMD_UNPIN, e);
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
        end else if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                req_if.data  <= pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response receiver: ready walks a 32-bit random pattern that pat_age renews.
    bit [31:0] stall_pat = '1;
    bit [4:0]  pat_pos   = '0;
    int        pat_age   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat <= '1;
                    1: stall_pat <= $urandom;
                    2: stall_pat <= $urandom | $urandom;
                    default: stall_pat <= $urandom & $urandom;
                endcase
                pat_age <= 63;
            end else begin
                pat_age <= pat_age - 1;
            end
            rsp_if.ready <= stall_pat[pat_pos];
            pat_pos      <= pat_pos + 1'b1;
        end
    end

    // Monitor: check each response transaction, then predict each accepted request.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;

        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                answered_cnt++;
                if (want_rsps.size() == 0) begin
                    $display("%0t: response with none expected, got slot %0d status %0d",
                             $time, got.slot_out, got.status);
                    mismatches++;
                end else begin
                    want = want_rsps.pop_front();
                    check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
                    check_field("needs_read", 32'(want.needs_read), 32'(got.needs_read));
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("status", 32'(want.status), 32'(got.status));
                end
            end
            if (req_if.valid && req_if.ready) begin
                want = cache_apply(req_if.data);
                want_rsps.push_back(want);
                if (t_status'(want.status) == ST_NO_BUF) begin
                    n_full++;
                end else if (t_status'(want.status) == ST_COUNT) begin
                    n_cnt_err++;
                end else if (t_cmd'(req_if.data.cmd) == CMD_ACQUIRE) begin
                    if (want.hit) begin
                        n_hit++;
                    end else begin
                        n_miss++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: reset, directed corner cases, then random batches.
    initial begin
        t_key k;
        int   directed_n;
        int   batch;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        for (int e = 0; e < NUM_SLOTS; e++) begin
            c_dev[e]   = '0;
            c_blk[e]   = '0;
            c_valid[e] = 1'b0;
            c_cnt[e]   = '0;
            c_time[e]  = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zeroed tags: device 0 block 0 hits way 0 of set 0, first needing a read.
        send(CMD_ACQUIRE, 16'h0, 32'h0, 9'h0, 32'h0);
        send(CMD_ACQUIRE, 16'h0, 32'h0, 9'h1FF, 32'hFFFF_FFFF);
        send(CMD_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF);
        // Release down to zero stamps the time; one more is refused with ST_COUNT.
        send(CMD_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 9'd0, 32'hFFFF_FFFF);
        send(CMD_RELEASE, 16'h0, 32'h0, 9'd0, 32'h0001_2345);
        send(CMD_RELEASE, 16'h0, 32'h0, 9'd0, 32'h0);
        send(CMD_UNPIN, 16'h0, 32'h0, 9'd5, 32'h0);
        // Last real entry, then slots past the end of the cache.
        send(CMD_PIN, 16'h0, 32'h0, 9'd415, 32'h0);
        send(CMD_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 9'd415, 32'hFFFF_FFFF);
        send(CMD_PIN, 16'h0, 32'h0, 9'd416, 32'h0);
        send(CMD_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 9'd511, 32'hFFFF_FFFF);
        send(CMD_UNPIN, 16'h0, 32'h0, 9'd511, 32'h0);
        // A new block in set 0 should skip way 0, which was released most recently.
        k = fresh_key(0);
        send_acquire(k);
        // Free, pin and re-acquire the entry taken for the all-ones key.
        send(CMD_RELEASE, 16'h0, 32'h0, 9'd160, 32'h0);
        send(CMD_PIN, 16'h0, 32'h0, 9'd160, 32'h0);
        send(CMD_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 9'h0, 32'h0);
        directed_n = issued_cnt;
        wait_idle();

        batch = 0;
        while (issued_cnt - directed_n < RAND_ITEMS) begin
            if (batch == 1 || batch == 7) begin
                fill_set();
            end else if (batch == 3) begin
                saturate_slot();
            end else if ($urandom_range(0, 9) == 0) begin
                fill_set();
            end else begin
                mix_batch();
            end
            wait_idle();
            batch++;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (want_rsps.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, want_rsps.size());
            mismatches += want_rsps.size();
        end
        $display("Sent %0d requests (%0d directed) in %0d cycles; %0d responses checked.",
                 issued_cnt, directed_n, cycles, answered_cnt);
        $display("Acquire hits %0d, misses %0d, set full %0d, count or slot errors %0d.",
                 n_hit, n_miss, n_full, n_cnt_err);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/hbc_pkg.sv
rtl/hbc_ifs.sv
rtl/hashed_buffer_cache_lru.sv
rtl/hbc_chk.sv
tb/hashed_buffer_cache_lru_tb.sv
